>>> hdl/epcal_pkg.sv
// ----------------------------------------------------------------------------
// epcal_pkg: shared constants for the epoch-seconds to calendar converter
// Reciprocals for the constant dividers, calendar anchors, pipeline latency
// and the month start table.
// ----------------------------------------------------------------------------
package epcal_pkg;

    // Pipeline depth from an accepted start beat to the done strobe
    localparam int unsigned LATENCY = 13;

    // floor(2^32 / D); quotient from the product high word is exact or one low
    localparam logic [31:0] RECIP_60   = 32'((64'h1_0000_0000) / 64'd60);
    localparam logic [31:0] RECIP_24   = 32'((64'h1_0000_0000) / 64'd24);
    localparam logic [31:0] RECIP_7    = 32'((64'h1_0000_0000) / 64'd7);
    localparam logic [31:0] RECIP_1461 = 32'((64'h1_0000_0000) / 64'd1461);

    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
    localparam logic [5:0]  MINS_PER_HOUR  = 6'd60;
    localparam logic [4:0]  HOURS_PER_DAY  = 5'd24;
    localparam logic [2:0]  DAYS_PER_WEEK  = 3'd7;
    localparam logic [10:0] DAYS_PER_BLOCK = 11'd1461;
    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
    localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd4;

    // Year counting starts on 1969-01-01 so each 4-year block ends in a leap year
    localparam logic [7:0]  BLOCK_BASE_YEAR = 8'd69;
    // 2100 (year 200) is not a leap year; 2100-03-01 is day 47541 after the epoch
    localparam logic [7:0]  YEAR_2100       = 8'd200;
    localparam logic [15:0] DAY_2100_MAR1   = 16'd47541;
    localparam logic [8:0]  YDAY_MAR1_LEAP  = 9'd60;

    // First day of year of month m (0 is January)
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        begin
            unique case (m)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            month_start = base + ((leap && (m >= 4'd2)) ? 9'd1 : 9'd0);
        end
    endfunction

endpackage

>>> hdl/epoch_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core: Unix seconds to broken-down UTC time
//
// Usage:
//   Input channel: drive seconds and raise start; a beat is taken at each
//   rising edge with start high and busy low. busy is always low, so a new
//   beat may be issued every cycle.
//   Result channel: done pulses for one cycle with second, minute, hour,
//   weekday, day_of_month, month, year_since_1900 and day_of_year valid in
//   that cycle. The receiver cannot hold results off and must take them then.
//   Throughput: one beat per cycle. The pipeline depth is set by the chain of
//   reciprocal-multiply dividers (by 60, 60, 24, 7 and 1461), each a product
//   stage followed by a correction stage, then the year and month stages.
//   Reset: rst_n clears all stage valid bits; beats in flight are dropped
//   and done stays low until new beats emerge.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] seconds,
    output logic        done,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [2:0]  weekday,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month,
    output logic [7:0]  year_since_1900,
    output logic [8:0]  day_of_year
);

    localparam int unsigned NSTAGE = epcal_pkg::LATENCY;

    // Stage valid bits
    logic [NSTAGE-1:0] valid_reg, valid_next;

    // Stage payload registers
    logic [31:0] s1_t_reg,    s1_t_next;
    logic [26:0] s1_q_reg,    s1_q_next;
    logic [26:0] s2_mt_reg,   s2_mt_next;
    logic [5:0]  s2_sec_reg,  s2_sec_next;
    logic [26:0] s3_mt_reg;
    logic [20:0] s3_q_reg,    s3_q_next;
    logic [5:0]  s3_sec_reg;
    logic [20:0] s4_ht_reg,   s4_ht_next;
    logic [5:0]  s4_min_reg,  s4_min_next;
    logic [5:0]  s4_sec_reg;
    logic [20:0] s5_ht_reg;
    logic [15:0] s5_q_reg,    s5_q_next;
    logic [5:0]  s5_min_reg,  s5_sec_reg;
    logic [15:0] s6_days_reg, s6_days_next;
    logic [4:0]  s6_hour_reg, s6_hour_next;
    logic [5:0]  s6_min_reg,  s6_sec_reg;
    logic [15:0] s7_w_reg,    s7_w_next;
    logic [12:0] s7_q7_reg,   s7_q7_next;
    logic [15:0] s7_dd_reg,   s7_dd_next;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_reg,  s7_sec_reg;
    logic [2:0]  s8_wday_reg, s8_wday_next;
    logic [15:0] s8_dd_reg;
    logic [5:0]  s8_bq_reg,   s8_bq_next;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_min_reg,  s8_sec_reg;
    logic [5:0]  s9_blk_reg,  s9_blk_next;
    logic [10:0] s9_rem_reg,  s9_rem_next;
    logic [2:0]  s9_wday_reg;
    logic [4:0]  s9_hour_reg;
    logic [5:0]  s9_min_reg,  s9_sec_reg;
    logic [7:0]  s10_year_reg, s10_year_next;
    logic [8:0]  s10_yday_reg, s10_yday_next;
    logic        s10_leap_reg, s10_leap_next;
    logic [2:0]  s10_wday_reg;
    logic [4:0]  s10_hour_reg;
    logic [5:0]  s10_min_reg, s10_sec_reg;
    logic [7:0]  s11_year_reg;
    logic [8:0]  s11_yday_reg, s11_yday_next;
    logic        s11_leap_reg, s11_leap_next;
    logic [2:0]  s11_wday_reg;
    logic [4:0]  s11_hour_reg;
    logic [5:0]  s11_min_reg, s11_sec_reg;
    logic [3:0]  s12_mon_reg,  s12_mon_next;
    logic [7:0]  s12_year_reg;
    logic [8:0]  s12_yday_reg;
    logic        s12_leap_reg;
    logic [2:0]  s12_wday_reg;
    logic [4:0]  s12_hour_reg;
    logic [5:0]  s12_min_reg, s12_sec_reg;
    logic [4:0]  s13_mday_reg, s13_mday_next;
    logic [3:0]  s13_mon_reg;
    logic [7:0]  s13_year_reg;
    logic [8:0]  s13_yday_reg;
    logic [2:0]  s13_wday_reg;
    logic [4:0]  s13_hour_reg;
    logic [5:0]  s13_min_reg, s13_sec_reg;

    // Combinational intermediates
    logic [63:0] prod1, prod3, prod5, prod7, prod8;
    logic [31:0] rem2;
    logic [26:0] rem4;
    logic [20:0] rem6;
    logic [15:0] rem8, rem9;
    logic [1:0]  yin10;
    logic [10:0] ysub10;
    logic [3:0]  mcount12;
    logic [8:0]  mstart13;

    // Never holds off input beats
    assign busy = 1'b0;

    // Valid bits advance one stage per cycle
    always_comb
    begin
        valid_next = {valid_reg[NSTAGE-2:0], start & ~busy};
    end

    // Stages 1-2: seconds / 60
    always_comb
    begin
        s1_t_next = seconds;
        prod1     = {32'd0, seconds} * {32'd0, epcal_pkg::RECIP_60};
        s1_q_next = prod1[58:32];

        rem2 = s1_t_reg - ({5'd0, s1_q_reg} * 32'd60);
        if (rem2[6:0] >= {1'b0, epcal_pkg::SECS_PER_MIN})
        begin
            s2_mt_next  = s1_q_reg + 27'd1;
            s2_sec_next = 6'(rem2[6:0] - {1'b0, epcal_pkg::SECS_PER_MIN});
        end
        else
        begin
            s2_mt_next  = s1_q_reg;
            s2_sec_next = rem2[5:0];
        end
    end

    // Stages 3-4: minutes / 60
    always_comb
    begin
        prod3     = {37'd0, s2_mt_reg} * {32'd0, epcal_pkg::RECIP_60};
        s3_q_next = prod3[52:32];

        rem4 = s3_mt_reg - ({6'd0, s3_q_reg} * 27'd60);
        if (rem4[6:0] >= {1'b0, epcal_pkg::MINS_PER_HOUR})
        begin
            s4_ht_next  = s3_q_reg + 21'd1;
            s4_min_next = 6'(rem4[6:0] - {1'b0, epcal_pkg::MINS_PER_HOUR});
        end
        else
        begin
            s4_ht_next  = s3_q_reg;
            s4_min_next = rem4[5:0];
        end
    end

    // Stages 5-6: hours / 24
    always_comb
    begin
        prod5     = {43'd0, s4_ht_reg} * {32'd0, epcal_pkg::RECIP_24};
        s5_q_next = prod5[47:32];

        rem6 = s5_ht_reg - ({5'd0, s5_q_reg} * 21'd24);
        if (rem6[5:0] >= {1'b0, epcal_pkg::HOURS_PER_DAY})
        begin
            s6_days_next = s5_q_reg + 16'd1;
            s6_hour_next = 5'(rem6[5:0] - {1'b0, epcal_pkg::HOURS_PER_DAY});
        end
        else
        begin
            s6_days_next = s5_q_reg;
            s6_hour_next = rem6[4:0];
        end
    end

    // Stage 7: weekday product; day count rebased to 1969 with 2100 leap day inserted
    always_comb
    begin
        s7_w_next  = s6_days_reg + {13'd0, epcal_pkg::EPOCH_WEEKDAY};
        prod7      = {48'd0, s7_w_next} * {32'd0, epcal_pkg::RECIP_7};
        s7_q7_next = prod7[44:32];
        s7_dd_next = s6_days_reg + {7'd0, epcal_pkg::DAYS_PER_YEAR}
                   + ((s6_days_reg >= epcal_pkg::DAY_2100_MAR1) ? 16'd1 : 16'd0);
    end

    // Stage 8: weekday correction; 4-year block product
    always_comb
    begin
        rem8 = s7_w_reg - ({3'd0, s7_q7_reg} * 16'd7);
        if (rem8[3:0] >= {1'b0, epcal_pkg::DAYS_PER_WEEK})
        begin
            s8_wday_next = 3'(rem8[3:0] - {1'b0, epcal_pkg::DAYS_PER_WEEK});
        end
        else
        begin
            s8_wday_next = rem8[2:0];
        end
        prod8      = {48'd0, s7_dd_reg} * {32'd0, epcal_pkg::RECIP_1461};
        s8_bq_next = prod8[37:32];
    end

    // Stage 9: block correction
    always_comb
    begin
        rem9 = s8_dd_reg - ({10'd0, s8_bq_reg} * 16'd1461);
        if (rem9[11:0] >= {1'b0, epcal_pkg::DAYS_PER_BLOCK})
        begin
            s9_blk_next = s8_bq_reg + 6'd1;
            s9_rem_next = 11'(rem9[11:0] - {1'b0, epcal_pkg::DAYS_PER_BLOCK});
        end
        else
        begin
            s9_blk_next = s8_bq_reg;
            s9_rem_next = rem9[10:0];
        end
    end

    // Stage 10: year within block; last year of a block is leap
    always_comb
    begin
        priority if (s9_rem_reg >= 11'd1095)
        begin
            yin10  = 2'd3;
            ysub10 = 11'd1095;
        end
        else if (s9_rem_reg >= 11'd730)
        begin
            yin10  = 2'd2;
            ysub10 = 11'd730;
        end
        else if (s9_rem_reg >= 11'd365)
        begin
            yin10  = 2'd1;
            ysub10 = 11'd365;
        end
        else
        begin
            yin10  = 2'd0;
            ysub10 = 11'd0;
        end
        s10_yday_next = 9'(s9_rem_reg - ysub10);
        s10_year_next = epcal_pkg::BLOCK_BASE_YEAR + {s9_blk_reg, 2'b00} + {6'd0, yin10};
        s10_leap_next = (yin10 == 2'd3);
    end

    // Stage 11: 2100 is common; drop the inserted leap day
    always_comb
    begin
        s11_leap_next = s10_leap_reg;
        s11_yday_next = s10_yday_reg;
        if (s10_year_reg == epcal_pkg::YEAR_2100)
        begin
            s11_leap_next = 1'b0;
            if (s10_yday_reg >= epcal_pkg::YDAY_MAR1_LEAP)
            begin
                s11_yday_next = s10_yday_reg - 9'd1;
            end
        end
    end

    // Stage 12: month = number of month starts passed after January
    always_comb
    begin
        mcount12 = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (s11_yday_reg >= epcal_pkg::month_start(4'(m), s11_leap_reg))
            begin
                mcount12 = mcount12 + 4'd1;
            end
        end
        s12_mon_next = mcount12;
    end

    // Stage 13: day of month
    always_comb
    begin
        mstart13      = epcal_pkg::month_start(s12_mon_reg, s12_leap_reg);
        s13_mday_next = 5'(s12_yday_reg - mstart13 + 9'd1);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_t_reg     <= s1_t_next;
        s1_q_reg     <= s1_q_next;

        s2_mt_reg    <= s2_mt_next;
        s2_sec_reg   <= s2_sec_next;

        s3_mt_reg    <= s2_mt_reg;
        s3_q_reg     <= s3_q_next;
        s3_sec_reg   <= s2_sec_reg;

        s4_ht_reg    <= s4_ht_next;
        s4_min_reg   <= s4_min_next;
        s4_sec_reg   <= s3_sec_reg;

        s5_ht_reg    <= s4_ht_reg;
        s5_q_reg     <= s5_q_next;
        s5_min_reg   <= s4_min_reg;
        s5_sec_reg   <= s4_sec_reg;

        s6_days_reg  <= s6_days_next;
        s6_hour_reg  <= s6_hour_next;
        s6_min_reg   <= s5_min_reg;
        s6_sec_reg   <= s5_sec_reg;

        s7_w_reg     <= s7_w_next;
        s7_q7_reg    <= s7_q7_next;
        s7_dd_reg    <= s7_dd_next;
        s7_hour_reg  <= s6_hour_reg;
        s7_min_reg   <= s6_min_reg;
        s7_sec_reg   <= s6_sec_reg;

        s8_wday_reg  <= s8_wday_next;
        s8_dd_reg    <= s7_dd_reg;
        s8_bq_reg    <= s8_bq_next;
        s8_hour_reg  <= s7_hour_reg;
        s8_min_reg   <= s7_min_reg;
        s8_sec_reg   <= s7_sec_reg;

        s9_blk_reg   <= s9_blk_next;
        s9_rem_reg   <= s9_rem_next;
        s9_wday_reg  <= s8_wday_reg;
        s9_hour_reg  <= s8_hour_reg;
        s9_min_reg   <= s8_min_reg;
        s9_sec_reg   <= s8_sec_reg;

        s10_year_reg <= s10_year_next;
        s10_yday_reg <= s10_yday_next;
        s10_leap_reg <= s10_leap_next;
        s10_wday_reg <= s9_wday_reg;
        s10_hour_reg <= s9_hour_reg;
        s10_min_reg  <= s9_min_reg;
        s10_sec_reg  <= s9_sec_reg;

        s11_year_reg <= s10_year_reg;
        s11_yday_reg <= s11_yday_next;
        s11_leap_reg <= s11_leap_next;
        s11_wday_reg <= s10_wday_reg;
        s11_hour_reg <= s10_hour_reg;
        s11_min_reg  <= s10_min_reg;
        s11_sec_reg  <= s10_sec_reg;

        s12_mon_reg  <= s12_mon_next;
        s12_year_reg <= s11_year_reg;
        s12_yday_reg <= s11_yday_reg;
        s12_leap_reg <= s11_leap_reg;
        s12_wday_reg <= s11_wday_reg;
        s12_hour_reg <= s11_hour_reg;
        s12_min_reg  <= s11_min_reg;
        s12_sec_reg  <= s11_sec_reg;

        s13_mday_reg <= s13_mday_next;
        s13_mon_reg  <= s12_mon_reg;
        s13_year_reg <= s12_year_reg;
        s13_yday_reg <= s12_yday_reg;
        s13_wday_reg <= s12_wday_reg;
        s13_hour_reg <= s12_hour_reg;
        s13_min_reg  <= s12_min_reg;
        s13_sec_reg  <= s12_sec_reg;
    end

    // Result beat
    assign done            = valid_reg[NSTAGE-1];
    assign second          = s13_sec_reg;
    assign minute          = s13_min_reg;
    assign hour            = s13_hour_reg;
    assign weekday         = s13_wday_reg;
    assign day_of_month    = s13_mday_reg;
    assign month           = s13_mon_reg;
    assign year_since_1900 = s13_year_reg;
    assign day_of_year     = s13_yday_reg;

endmodule

>>> hdl/epcal_checker.sv
// ----------------------------------------------------------------------------
// epcal_checker: port-level checks for the calendar converter
// Ties each result beat to an input beat a fixed latency earlier and checks
// that result fields stay within calendar ranges.
// ----------------------------------------------------------------------------
module epcal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] seconds,
    input logic        done,
    input logic [5:0]  second,
    input logic [5:0]  minute,
    input logic [4:0]  hour,
    input logic [2:0]  weekday,
    input logic [4:0]  day_of_month,
    input logic [3:0]  month,
    input logic [7:0]  year_since_1900,
    input logic [8:0]  day_of_year
);

    // Every accepted beat yields a result after the pipeline depth
    a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(epcal_pkg::LATENCY) done)
        else $error("accepted beat produced no result");

    // No result without a matching input beat
    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, epcal_pkg::LATENCY))
        else $error("result without an accepted beat");

    // Time-of-day fields in range
    a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24)
                 && (weekday < 3'd7))
        else $error("time-of-day field out of range");

    // Date fields in range; day 365 only on December 31
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (day_of_month != 5'd0) && (month < 4'd12)
                 && (year_since_1900 >= 8'd70) && (year_since_1900 <= 8'd206)
                 && (day_of_year <= 9'd365)
                 && ((day_of_year != 9'd365)
                     || ((month == 4'd11) && (day_of_month == 5'd31))))
        else $error("date field out of range");

endmodule

bind epoch_seconds_to_calendar_core epcal_checker u_epcal_checker (.*);
